@@ design/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, register map and result types for the schedule evaluator.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int TIME_W   = 24;
	localparam int MAX_PROC = 8;
	localparam int PROC_W   = $clog2(MAX_PROC);
	localparam int CNT_W    = 4;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [PROC_W-1:0] proc_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam time_t TIME_MAX      = {TIME_W{1'b1}};
	localparam cnt_t  NUM_PROC_RST  = CNT_W'(MAX_PROC);

	typedef enum logic [ADDR_W-3:0] {
		REG_NUM_PROCESSORS = 1'b0
	} reg_idx_t;

	typedef struct packed {
		time_t completion_time;
		time_t turnaround_time;
		time_t waiting_time;
		time_t response_time;
		time_t makespan;
		logic  batch_done;
		logic  bad_processor;
	} result_t;

	typedef struct packed {
		logic  wr;
		logic  clear;
		time_t wdata;
	} busy_upd_t;

endpackage

@@ design/mse_eval.sv @@
// ----------------------------------------------------------------------------
// mse_eval
// Evaluates one task against the busy-until table: start, completion,
// derived times, makespan over enabled processors and the table update.
// ----------------------------------------------------------------------------
module mse_eval
	import mse_pkg::*;
(
	input  time_t     busy_until [MAX_PROC],
	input  cnt_t      num_processors,
	input  proc_t     processor_index,
	input  time_t     task_arrival,
	input  time_t     burst_time,
	input  logic      last_task,
	output result_t   result,
	output busy_upd_t upd
);

	cnt_t             count;
	logic             bad;
	time_t            busy_sel;
	time_t            start;
	logic [TIME_W:0]  sum;
	time_t            completion;
	time_t            turnaround;
	time_t            lvl0 [MAX_PROC];
	time_t            lvl1 [MAX_PROC/2];
	time_t            lvl2 [MAX_PROC/4];
	time_t            span;

	always_comb begin
		count      = (num_processors > NUM_PROC_RST) ? NUM_PROC_RST : num_processors;
		bad        = {1'b0, processor_index} >= count;
		busy_sel   = busy_until[processor_index];
		start      = (busy_sel > task_arrival) ? busy_sel : task_arrival;
		sum        = {1'b0, start} + {1'b0, burst_time};
		completion = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		turnaround = completion - task_arrival;
	end

	// makespan: registered table with this task's completion substituted
	always_comb begin
		for (int i = 0; i < MAX_PROC; i++) begin
			if (CNT_W'(i) >= count)
				lvl0[i] = '0;
			else if (PROC_W'(i) == processor_index)
				lvl0[i] = completion;
			else
				lvl0[i] = busy_until[i];
		end
		for (int i = 0; i < MAX_PROC/2; i++)
			lvl1[i] = (lvl0[2*i] > lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
		for (int i = 0; i < MAX_PROC/4; i++)
			lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
		span = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
	end

	always_comb begin
		result = '0;
		if (bad) begin
			result.bad_processor = 1'b1;
		end else begin
			result.completion_time = completion;
			result.turnaround_time = turnaround;
			result.waiting_time    = (turnaround >= burst_time) ? turnaround - burst_time : '0;
			result.response_time   = start - task_arrival;
			result.makespan        = last_task ? span : '0;
			result.batch_done      = last_task;
		end
		upd.wr    = !bad;
		upd.clear = !bad && last_task;
		upd.wdata = completion;
	end

endmodule

@@ design/multiprocessor_schedule_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// multiprocessor_schedule_evaluator_unit
// Task schedule evaluator with busy-until table and APB configuration.
// ----------------------------------------------------------------------------
// One task word is taken per cycle unless a held result word stalls the
// pipe. Each task passes a task register, then one pass of max/add/subtract
// logic plus the makespan compare tree into the result register, which
// drives the outputs. The busy-until table is updated at the same edge the
// result is registered, so a following task for the same processor sees it
// with no bubble.
// The last task of a batch reports the makespan over the enabled
// processors and clears the table. A processor index at or above the
// configured count returns only bad_processor and leaves the table alone.
// ----------------------------------------------------------------------------
module multiprocessor_schedule_evaluator_unit
	import mse_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                task_valid,
	output logic                task_ready,
	input  proc_t               processor_index,
	input  time_t               task_arrival,
	input  time_t               burst_time,
	input  logic                last_task,
	output logic                result_valid,
	input  logic                result_ready,
	output time_t               completion_time,
	output time_t               turnaround_time,
	output time_t               waiting_time,
	output time_t               response_time,
	output time_t               makespan,
	output logic                batch_done,
	output logic                bad_processor
);

	cnt_t      num_processors_q;
	time_t     busy_until_q [MAX_PROC];

	logic      valid_s1;
	proc_t     proc_s1;
	time_t     arrival_s1;
	time_t     burst_s1;
	logic      last_s1;

	logic      valid_s2;
	result_t   result_s2;

	result_t   result;
	busy_upd_t upd;
	logic      adv_s1;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_NUM_PROCESSORS) ?
		DATA_W'(num_processors_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_processors_q <= NUM_PROC_RST;
		end else if (psel && penable && pwrite && pready &&
				paddr[ADDR_W-1:2] == REG_NUM_PROCESSORS) begin
			num_processors_q <= pwdata[CNT_W-1:0];
		end
	end

	// handshake
	assign adv_s1     = valid_s1 && (!valid_s2 || result_ready);
	assign task_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (task_ready)
				valid_s1 <= task_valid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (result_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (task_valid && task_ready) begin
			proc_s1    <= processor_index;
			arrival_s1 <= task_arrival;
			burst_s1   <= burst_time;
			last_s1    <= last_task;
		end
		if (adv_s1)
			result_s2 <= result;
	end

	mse_eval u_eval (
		.busy_until      (busy_until_q),
		.num_processors  (num_processors_q),
		.processor_index (proc_s1),
		.task_arrival    (arrival_s1),
		.burst_time      (burst_s1),
		.last_task       (last_s1),
		.result          (result),
		.upd             (upd)
	);

	// busy-until table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PROC; i++)
				busy_until_q[i] <= '0;
		end else if (adv_s1) begin
			for (int i = 0; i < MAX_PROC; i++) begin
				if (upd.clear)
					busy_until_q[i] <= '0;
				else if (upd.wr && PROC_W'(i) == proc_s1)
					busy_until_q[i] <= upd.wdata;
			end
		end
	end

	assign result_valid    = valid_s2;
	assign completion_time = result_s2.completion_time;
	assign turnaround_time = result_s2.turnaround_time;
	assign waiting_time    = result_s2.waiting_time;
	assign response_time   = result_s2.response_time;
	assign makespan        = result_s2.makespan;
	assign batch_done      = result_s2.batch_done;
	assign bad_processor   = result_s2.bad_processor;

endmodule

@@ design/mse_checker.sv @@
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks on result words of the schedule evaluator.
// ----------------------------------------------------------------------------
module mse_checker
	import mse_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  result_valid,
	input logic  result_ready,
	input time_t completion_time,
	input time_t turnaround_time,
	input time_t waiting_time,
	input time_t response_time,
	input time_t makespan,
	input logic  batch_done,
	input logic  bad_processor
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(completion_time) && $stable(makespan) &&
			$stable(bad_processor))
		else $error("result word changed while stalled");

	// bad processor word carries no timing
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_processor |->
			completion_time == '0 && turnaround_time == '0 && waiting_time == '0 &&
			response_time == '0 && makespan == '0 && !batch_done)
		else $error("bad processor word has nonzero fields");

	// makespan covers this task
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && batch_done |-> makespan >= completion_time)
		else $error("makespan below completion");

	// response and waiting bounded by turnaround, turnaround by completion
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !bad_processor |->
			response_time <= turnaround_time && waiting_time <= turnaround_time &&
			turnaround_time <= completion_time)
		else $error("time fields out of order");

endmodule

bind multiprocessor_schedule_evaluator_unit mse_checker u_mse_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_ready    (result_ready),
	.completion_time (completion_time),
	.turnaround_time (turnaround_time),
	.waiting_time    (waiting_time),
	.response_time   (response_time),
	.makespan        (makespan),
	.batch_done      (batch_done),
	.bad_processor   (bad_processor)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the schedule evaluator. Task words go in over a
// valid/ready channel with bursty pacing. Each accepted word is scored
// against a local busy-until table model. Result words are checked field by
// field in arrival order while the receiver stalls on its own pattern.
// Directed words cover the time extremes, saturation, queuing behind a busy
// processor, batch ends and processor counts of zero, one, eight and above
// eight. One long receiver hold-off follows, then random batches under
// several register settings with full drains in between.
// ----------------------------------------------------------------------------
module testbench
	import mse_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PIPE_LATENCY   = 2;
	localparam int HOLD_CYCLES    = 300;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              task_valid;
	logic              task_ready;
	proc_t             processor_index;
	time_t             task_arrival;
	time_t             burst_time;
	logic              last_task;
	logic              result_valid;
	logic              result_ready;
	time_t             completion_time;
	time_t             turnaround_time;
	time_t             waiting_time;
	time_t             response_time;
	time_t             makespan;
	logic              batch_done;
	logic              bad_processor;

	multiprocessor_schedule_evaluator_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.task_valid      (task_valid),
		.task_ready      (task_ready),
		.processor_index (processor_index),
		.task_arrival    (task_arrival),
		.burst_time      (burst_time),
		.last_task       (last_task),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.completion_time (completion_time),
		.turnaround_time (turnaround_time),
		.waiting_time    (waiting_time),
		.response_time   (response_time),
		.makespan        (makespan),
		.batch_done      (batch_done),
		.bad_processor   (bad_processor)
	);

	// scoreboard model state
	time_t       busy_table [MAX_PROC];
	cnt_t        proc_count;
	result_t     pending_results [$];

	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned batches_ended;
	int unsigned bad_words;
	int unsigned saturated_words;
	int unsigned reg_writes;
	int unsigned idle_cycles;

	bit          sender_gaps;
	int          burst_left;
	int          hold_request;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int enabled_procs();
		return (int'(proc_count) > MAX_PROC) ? MAX_PROC : int'(proc_count);
	endfunction

	function automatic result_t schedule_task(proc_t p, time_t arr, time_t brst, logic lst);
		result_t           r;
		int                cnt;
		time_t             start;
		logic [TIME_W:0]   sum;
		cnt = enabled_procs();
		r = '0;
		if (int'(p) >= cnt) begin
			r.bad_processor = 1'b1;
			bad_words++;
			return r;
		end
		start = (busy_table[p] > arr) ? busy_table[p] : arr;
		sum = {1'b0, start} + {1'b0, brst};
		if (sum > {1'b0, TIME_MAX}) begin
			r.completion_time = TIME_MAX;
			saturated_words++;
		end else begin
			r.completion_time = sum[TIME_W-1:0];
		end
		r.turnaround_time = r.completion_time - arr;
		r.waiting_time = (r.turnaround_time >= brst) ? r.turnaround_time - brst : '0;
		r.response_time = start - arr;
		busy_table[p] = r.completion_time;
		if (lst) begin
			for (int i = 0; i < cnt; i++)
				if (busy_table[i] > r.makespan)
					r.makespan = busy_table[i];
			for (int i = 0; i < MAX_PROC; i++)
				busy_table[i] = '0;
			r.batch_done = 1'b1;
			batches_ended++;
		end
		return r;
	endfunction

	task automatic send_task_word(proc_t p, time_t arr, time_t brst, logic lst);
		int gap;
		if (sender_gaps) begin
			if (burst_left <= 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 24);
				repeat (gap) begin
					@(negedge clk);
					task_valid <= 1'b0;
				end
			end
			burst_left--;
		end
		@(negedge clk);
		task_valid      <= 1'b1;
		processor_index <= p;
		task_arrival    <= arr;
		burst_time      <= brst;
		last_task       <= lst;
		do @(posedge clk); while (!task_ready);
		pending_results.push_back(schedule_task(p, arr, brst, lst));
		words_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		task_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 1) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_NUM_PROCESSORS)
			proc_count = value[CNT_W-1:0];
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_proc_count(int unsigned value);
		drain_results();
		// upper data bits are junk, only the low nibble is stored
		apb_write(REG_NUM_PROCESSORS,
			{(DATA_W-CNT_W)'($urandom() >> CNT_W), cnt_t'(value)});
	endtask

	function automatic time_t pick_time(int unsigned span);
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return TIME_MAX;
			2:       return time_t'(TIME_MAX - $urandom_range(0, 255));
			3, 4:    return time_t'($urandom());
			default: return time_t'($urandom_range(0, span));
		endcase
	endfunction

	task automatic test_directed_timing();
		sender_gaps = 1'b0;
		send_task_word(3'd0, 24'd0, 24'd0, 1'b0);
		send_task_word(3'd7, TIME_MAX, TIME_MAX, 1'b0);
		send_task_word(3'd7, 24'd0, 24'd5, 1'b0);
		send_task_word(3'd1, 24'd100, 24'd50, 1'b0);
		send_task_word(3'd1, 24'd120, 24'd30, 1'b0);
		send_task_word(3'd1, 24'd400, 24'd0, 1'b0);
		send_task_word(3'd0, 24'hAAAAAA, 24'h555555, 1'b0);
		send_task_word(3'd2, 24'h555555, 24'hAAAAAA, 1'b1);
		send_task_word(3'd3, 24'd5, 24'd5, 1'b1);
	endtask

	task automatic test_directed_counts();
		set_proc_count(1);
		send_task_word(3'd0, 24'd10, 24'd10, 1'b0);
		send_task_word(3'd1, 24'd0, 24'd0, 1'b1);
		send_task_word(3'd7, TIME_MAX, TIME_MAX, 1'b1);
		send_task_word(3'd0, 24'd15, 24'd1, 1'b1);
		set_proc_count(0);
		send_task_word(3'd0, 24'd1, 24'd1, 1'b1);
		send_task_word(3'd7, 24'd2, 24'd2, 1'b0);
		set_proc_count(15);
		send_task_word(3'd7, 24'd1, 24'd2, 1'b0);
		send_task_word(3'd0, 24'd3, 24'd4, 1'b1);
		set_proc_count(9);
		send_task_word(3'd7, 24'd50, 24'd50, 1'b1);
	endtask

	task automatic test_backpressure();
		set_proc_count(8);
		sender_gaps = 1'b0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 60; i++)
			send_task_word(proc_t'($urandom_range(0, 7)), time_t'($urandom_range(0, 500)),
				time_t'($urandom_range(0, 100)), (i % 6) == 5);
		drain_results();
	endtask

	task automatic run_batches(int unsigned n_words);
		int unsigned sent;
		int          len;
		int          cnt;
		int          t;
		proc_t       p;
		time_t       arr;
		time_t       brst;
		logic        lst;
		sent = 0;
		cnt = enabled_procs();
		while (sent < n_words) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
			sender_gaps = ($urandom_range(0, 4) != 0);
			t = ($urandom_range(0, 5) == 0) ? int'(TIME_MAX) - 5000 : $urandom_range(0, 1000);
			for (int k = 0; k < len; k++) begin
				if (cnt > 0 && $urandom_range(0, 9) != 0)
					p = proc_t'($urandom_range(0, cnt - 1));
				else
					p = proc_t'($urandom_range(0, 7));
				if ($urandom_range(0, 1) == 0) begin
					t += $urandom_range(0, 64);
					if (t > int'(TIME_MAX))
						t = int'(TIME_MAX);
					arr = time_t'(t);
				end else begin
					arr = pick_time(4000);
				end
				brst = ($urandom_range(0, 3) == 0) ? pick_time(100000) :
					time_t'($urandom_range(0, 200));
				// mostly well-formed batches, a few with a stray last flag
				lst = ($urandom_range(0, 15) == 0) ? logic'($urandom_range(0, 1)) : (k == len - 1);
				send_task_word(p, arr, brst, lst);
				sent++;
			end
		end
	endtask

	task automatic test_random_batches();
		int          settings [9] = '{8, 1, 15, 0, 5, 2, -1, -1, -1};
		int unsigned value;
		foreach (settings[i]) begin
			value = (settings[i] < 0) ? $urandom_range(1, 15) : settings[i];
			set_proc_count(value);
			run_batches((value == 0) ? 30 : 200);
		end
	endtask

	// receiver ready pattern, with an optional long hold-off
	initial begin
		int seg;
		int pct;
		int hold_left;
		result_ready = 1'b0;
		hold_left = 0;
		forever begin
			seg = $urandom_range(20, 200);
			case ($urandom_range(0, 4))
				0:       pct = 0;
				1:       pct = 10;
				2:       pct = 30;
				3:       pct = 60;
				default: pct = 90;
			endcase
			repeat (seg) begin
				@(negedge clk);
				if (hold_request > 0) begin
					hold_left = hold_request;
					hold_request = 0;
				end
				if (hold_left > 0) begin
					hold_left--;
					result_ready <= 1'b0;
				end else begin
					result_ready <= ($urandom_range(0, 99) >= pct);
				end
			end
		end
	end

	task automatic check_field(string name, time_t want, time_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result word: expected none, actual completion %0h",
					$time, completion_time);
			end else begin
				want = pending_results.pop_front();
				check_field("completion_time", want.completion_time, completion_time);
				check_field("turnaround_time", want.turnaround_time, turnaround_time);
				check_field("waiting_time", want.waiting_time, waiting_time);
				check_field("response_time", want.response_time, response_time);
				check_field("makespan", want.makespan, makespan);
				check_field("batch_done", time_t'(want.batch_done), time_t'(batch_done));
				check_field("bad_processor", time_t'(want.bad_processor),
					time_t'(bad_processor));
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (task_valid && task_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("[multiprocessor_schedule_evaluator_unit] ERROR");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		task_valid      = 1'b0;
		processor_index = '0;
		task_arrival    = '0;
		burst_time      = '0;
		last_task       = 1'b0;
		mismatches      = 0;
		words_sent      = 0;
		batches_ended   = 0;
		bad_words       = 0;
		saturated_words = 0;
		reg_writes      = 0;
		sender_gaps     = 1'b0;
		burst_left      = 0;
		hold_request    = 0;
		proc_count      = NUM_PROC_RST;
		for (int i = 0; i < MAX_PROC; i++)
			busy_table[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_timing();
		test_directed_counts();
		test_backpressure();
		test_random_batches();

		drain_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatches++;
			$display("%0t leftover: expected %0d more result words, actual 0",
				$time, pending_results.size());
		end
		$display("covered %0d task words, %0d batch ends, %0d bad-processor words, %0d saturated",
			words_sent, batches_ended, bad_words, saturated_words);
		$display("%0d count register writes, counts 0 to 15, long receiver hold-off, drains",
			reg_writes);
		if (mismatches == 0) begin
			$display("[multiprocessor_schedule_evaluator_unit] OK");
		end else begin
			$display("[multiprocessor_schedule_evaluator_unit] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/mse_pkg.sv
design/mse_eval.sv
design/multiprocessor_schedule_evaluator_unit.sv
design/mse_checker.sv
sim/testbench.sv
